@@ hw/rtl/rsge_pkg.sv @@
// rsge_pkg: shared types, constants and channel arithmetic for the
// squared gradient energy block; used by every module under hw/rtl
package rsge_pkg;

  // field and register widths
  localparam int unsigned PixelW      = 24;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned LineWidthW  = 13;
  localparam int unsigned EnergyW     = 48;
  localparam int unsigned SquareW     = 2 * ChanW;
  localparam int unsigned PairW       = SquareW + 2;
  localparam int unsigned AddW        = PairW + 1;

  // defaults and reset values
  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned SumBitsDefault  = 48;
  localparam logic [LineWidthW-1:0] LineWidthReset = LineWidthW'(4096);

  // queue between front and back
  localparam int unsigned QueueDepth = 2;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [PixelW-1:0] above;
    logic [PixelW-1:0] left;
    logic              scored;
    logic              last;
  } item_t;

  // squared difference of one 8-bit channel
  function automatic logic [SquareW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                                  input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SquareW'(d) * SquareW'(d);
  endfunction

  // sum of squared channel differences of two pixels
  function automatic logic [PairW-1:0] pair_energy(input logic [PixelW-1:0] a,
                                                    input logic [PixelW-1:0] b);
    logic [PairW-1:0] r;
    logic [PairW-1:0] g;
    logic [PairW-1:0] bl;
    r  = PairW'(sq_diff(a[7:0],   b[7:0]));
    g  = PairW'(sq_diff(a[15:8],  b[15:8]));
    bl = PairW'(sq_diff(a[23:16], b[23:16]));
    return r + g + bl;
  endfunction

endpackage

@@ hw/rtl/rsge_front.sv @@
// rsge_front: accepts pixels, tracks row and column, keeps the line store
// and classifies each pixel; depends on rsge_pkg
module rsge_front #(
  parameter int unsigned MAX_WIDTH = rsge_pkg::MaxWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               line_width_we_i,
  input  logic [rsge_pkg::LineWidthW-1:0]    line_width_i,
  input  logic                               pixel_valid_i,
  output logic                               pixel_ready_o,
  input  logic [rsge_pkg::PixelW-1:0]        pixel_i,
  input  logic                               last_pixel_i,
  output logic                               item_valid_o,
  input  logic                               item_ready_i,
  output rsge_pkg::item_t                    item_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CmpW = (ColW + 1 > rsge_pkg::LineWidthW) ?
                                 ColW + 1 : rsge_pkg::LineWidthW;

  logic [rsge_pkg::LineWidthW-1:0] line_width_q;
  logic [ColW-1:0]                 col_q, col_d;
  logic                            past_row_q, past_row_d;
  logic [rsge_pkg::PixelW-1:0]     left_q;
  logic                            valid_q;
  logic [rsge_pkg::PixelW-1:0]     pix_q;
  logic [rsge_pkg::PixelW-1:0]     above_q;
  logic [rsge_pkg::PixelW-1:0]     prev_q;
  logic                            scored_q;
  logic                            last_q;
  logic [rsge_pkg::PixelW-1:0]     row_mem [MAX_WIDTH];
  logic                            accept;
  logic [CmpW-1:0]                 width_req;
  logic [CmpW-1:0]                 width_used;
  logic [ColW:0]                   col_inc;
  logic                            wrap;

  assign accept        = pixel_valid_i & pixel_ready_o;
  assign pixel_ready_o = ~valid_q | item_ready_i;

  // width in use, held to the supported range
  always_comb begin
    width_req = CmpW'(line_width_q);
    if (width_req < CmpW'(2)) begin
      width_used = CmpW'(2);
    end else if (width_req > CmpW'(MAX_WIDTH)) begin
      width_used = CmpW'(MAX_WIDTH);
    end else begin
      width_used = width_req;
    end
  end

  // column advance and row wrap
  always_comb begin
    col_inc    = {1'b0, col_q} + (ColW + 1)'(1);
    wrap       = CmpW'(col_inc) >= width_used;
    col_d      = wrap ? '0 : col_inc[ColW-1:0];
    past_row_d = past_row_q | wrap;
    if (last_pixel_i) begin
      col_d      = '0;
      past_row_d = 1'b0;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= rsge_pkg::LineWidthReset;
    end else if (line_width_we_i) begin
      line_width_q <= line_width_i;
    end
  end

  // position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      past_row_q <= 1'b0;
      left_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        col_q      <= col_d;
        past_row_q <= past_row_d;
        left_q     <= last_pixel_i ? '0 : pixel_i;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (item_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // line store, read before write at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q      <= row_mem[col_q];
      row_mem[col_q] <= pixel_i;
    end
  end

  // classified beat held for the queue
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= pixel_i;
      prev_q   <= left_q;
      scored_q <= past_row_q & (col_q != '0);
      last_q   <= last_pixel_i;
    end
  end

  assign item_valid_o  = valid_q;
  assign item_o.pixel  = pix_q;
  assign item_o.above  = above_q;
  assign item_o.left   = prev_q;
  assign item_o.scored = scored_q;
  assign item_o.last   = last_q;

endmodule

@@ hw/rtl/rsge_queue.sv @@
// rsge_queue: short register queue between front and back so each side
// stalls on its own; depends on rsge_pkg
module rsge_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rsge_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rsge_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (rsge_pkg::QueueDepth > 1) ?
                                 $clog2(rsge_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rsge_pkg::QueueDepth + 1);

  rsge_pkg::item_t entries_q [rsge_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(rsge_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(rsge_pkg::QueueDepth - 1)) ? '0 :
                    wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(rsge_pkg::QueueDepth - 1)) ? '0 :
                    rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hw/rtl/rsge_back.sv @@
// rsge_back: squares channel differences, accumulates with saturation and
// holds the frame total for the output; depends on rsge_pkg
module rsge_back #(
  parameter int unsigned SUM_BITS = rsge_pkg::SumBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  rsge_pkg::item_t                  item_i,
  output logic                             energy_valid_o,
  input  logic                             energy_ready_i,
  output logic [rsge_pkg::EnergyW-1:0]     total_energy_o
);

  logic                         add_valid_q;
  logic [rsge_pkg::AddW-1:0]    add_q;
  logic                         add_scored_q;
  logic                         add_last_q;
  logic                         add_fire;
  logic                         add_ready;
  logic [SUM_BITS-1:0]          sum_q;
  logic [SUM_BITS-1:0]          sum_nxt;
  logic [SUM_BITS:0]            sum_ext;
  logic                         out_valid_q;
  logic [rsge_pkg::EnergyW-1:0] out_q;

  // a non-final beat always drains; a final one needs the output free
  assign add_fire     = add_valid_q &
                        (~add_last_q | ~out_valid_q | energy_ready_i);
  assign add_ready    = ~add_valid_q | add_fire;
  assign item_ready_o = add_ready;

  // energy of one pixel against its upper and left neighbors
  always_ff @(posedge clk_i) begin
    if (item_valid_i && add_ready) begin
      add_q <= rsge_pkg::AddW'(rsge_pkg::pair_energy(item_i.pixel, item_i.above)) +
               rsge_pkg::AddW'(rsge_pkg::pair_energy(item_i.pixel, item_i.left));
      add_scored_q <= item_i.scored;
      add_last_q   <= item_i.last;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(add_q);
    if (!add_scored_q) begin
      sum_nxt = sum_q;
    end else if (sum_ext[SUM_BITS]) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = sum_ext[SUM_BITS-1:0];
    end
  end

  // control, accumulator and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_valid_q <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_valid_i && add_ready) begin
        add_valid_q <= 1'b1;
      end else if (add_fire) begin
        add_valid_q <= 1'b0;
      end
      if (add_fire) begin
        sum_q <= add_last_q ? '0 : sum_nxt;
      end
      if (add_fire && add_last_q) begin
        out_valid_q <= 1'b1;
      end else if (energy_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_fire && add_last_q) begin
      out_q <= rsge_pkg::EnergyW'(sum_nxt);
    end
  end

  assign energy_valid_o = out_valid_q;
  assign total_energy_o = out_q;

`ifndef SYNTHESIS
  // frame end leaves a cleared accumulator
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_fire && add_last_q) |=> (sum_q == '0))
    else $error("accumulator not cleared after frame end");

  // within a frame the sum never falls
  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_fire && !add_last_q) |=> (sum_q >= $past(sum_q)))
    else $error("accumulator decreased within a frame");

  // a total appears only after a final beat was folded in
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(add_fire && add_last_q))
    else $error("output raised without a final beat");
`endif

endmodule

@@ hw/rtl/rgb_squared_gradient_energy.sv @@
// rgb_squared_gradient_energy: one pixel per cycle unless stalled; the frame
// total is shown after the last beat passes front, queue and add stage if the
// output is free; the single-port line store sets throughput: one beat each
// reset clears counters, accumulator and queue; the line store is not cleared
// and first-row reads are not scored, so no clearing pass follows reset
// line_width resets to 4096
module rgb_squared_gradient_energy #(
  parameter int unsigned MAX_WIDTH = rsge_pkg::MaxWidthDefault,
  parameter int unsigned SUM_BITS  = rsge_pkg::SumBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             line_width_we_i,
  input  logic [rsge_pkg::LineWidthW-1:0]  line_width_i,
  input  logic                             pixel_valid_i,
  output logic                             pixel_ready_o,
  input  logic [rsge_pkg::PixelW-1:0]      pixel_i,
  input  logic                             last_pixel_i,
  output logic                             energy_valid_o,
  input  logic                             energy_ready_i,
  output logic [rsge_pkg::EnergyW-1:0]     total_energy_o
);

  logic            front_valid;
  logic            front_ready;
  rsge_pkg::item_t front_item;
  logic            back_valid;
  logic            back_ready;
  rsge_pkg::item_t back_item;

  // accept and classify
  rsge_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_width_we_i(line_width_we_i),
    .line_width_i   (line_width_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .last_pixel_i   (last_pixel_i),
    .item_valid_o   (front_valid),
    .item_ready_i   (front_ready),
    .item_o         (front_item)
  );

  // decoupling queue
  rsge_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_item_i (front_item),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_item_o  (back_item)
  );

  // energy and accumulation
  rsge_back #(
    .SUM_BITS(SUM_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .energy_valid_o(energy_valid_o),
    .energy_ready_i(energy_ready_i),
    .total_energy_o(total_energy_o)
  );

endmodule
